>>> design/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types, register indexes and reset values of the debounced power
// sequencer.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int DPS_QUEUE_DEPTH = 2;

  localparam int DPS_BUTTONS_W  = 4;
  localparam int DPS_CFG_IDX_W  = 3;
  localparam int DPS_CFG_DATA_W = 16;

  localparam logic [DPS_CFG_IDX_W-1:0] REG_STABLE_TICKS      = 3'd0;
  localparam logic [DPS_CFG_IDX_W-1:0] REG_POWER_ON_DELAY    = 3'd1;
  localparam logic [DPS_CFG_IDX_W-1:0] REG_SHORT_PULSE_TICKS = 3'd2;
  localparam logic [DPS_CFG_IDX_W-1:0] REG_LONG_PULSE_TICKS  = 3'd3;
  localparam logic [DPS_CFG_IDX_W-1:0] REG_BLINK_HALF_PERIOD = 3'd4;

  localparam logic [7:0]  RESET_STABLE_TICKS      = 8'd5;
  localparam logic [15:0] RESET_POWER_ON_DELAY    = 16'd2000;
  localparam logic [15:0] RESET_SHORT_PULSE_TICKS = 16'd100;
  localparam logic [15:0] RESET_LONG_PULSE_TICKS  = 16'd500;
  localparam logic [7:0]  RESET_BLINK_HALF_PERIOD = 8'd250;

  localparam logic [1:0] MODE_CODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_CODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_CODE_ON   = 2'd2;

  localparam int BTN_OFF   = 0;
  localparam int BTN_START = 1;

  typedef struct packed {
    logic [7:0]  stable_ticks;
    logic [15:0] power_on_delay;
    logic [15:0] short_pulse_ticks;
    logic [15:0] long_pulse_ticks;
    logic [7:0]  blink_half_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               power_mode;
    logic                     pulse_active;
    logic                     status_lamp;
    logic                     ready_lamp;
    logic [DPS_BUTTONS_W-1:0] pressed_buttons;
  } result_t;

endpackage

>>> design/debounced_power_sequencer_top.sv
// ----------------------------------------------------------------------------
// debounced_power_sequencer_top
// Debounces four active-low buttons and sequences power, pulse and lamps.
//
//   channel  handshake        payload
//   -------  ---------------  ---------------------------------------------
//   input    push / full      raw_buttons
//   result   pop / empty      power_mode, pulse_active, status_lamp,
//                             ready_lamp, pressed_buttons
//   config   cfg_write        cfg_index, cfg_data
//
// One beat per cycle in and out while no queue stalls; a result is written to the
// middle queue and then to the result queue before it shows. The debounce front
// and the sequencer back are each combinational over registered state, split by
// a queue so either side can stall alone. A full result queue stalls the back;
// the front stalls only when the middle queue fills as well, and full follows it.
// rst is synchronous; it empties both queues and restores register defaults.
// ----------------------------------------------------------------------------
module debounced_power_sequencer_top #(
  parameter int QUEUE_DEPTH = dps_pkg::DPS_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [dps_pkg::DPS_BUTTONS_W-1:0]  raw_buttons,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        power_mode,
  output logic                              pulse_active,
  output logic                              status_lamp,
  output logic                              ready_lamp,
  output logic [dps_pkg::DPS_BUTTONS_W-1:0]  pressed_buttons,
  input  logic                              cfg_write,
  input  logic [dps_pkg::DPS_CFG_IDX_W-1:0]  cfg_index,
  input  logic [dps_pkg::DPS_CFG_DATA_W-1:0] cfg_data
);
  import dps_pkg::*;

  cfg_t                     cfg;
  logic                     accept;
  logic [DPS_BUTTONS_W-1:0] front_flags;
  logic [DPS_BUTTONS_W-1:0] mid_flags;
  logic                     mid_full;
  logic                     mid_empty;
  logic                     out_full;
  logic                     step;
  result_t                  back_result;
  result_t                  out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_ticks      <= RESET_STABLE_TICKS;
      cfg.power_on_delay    <= RESET_POWER_ON_DELAY;
      cfg.short_pulse_ticks <= RESET_SHORT_PULSE_TICKS;
      cfg.long_pulse_ticks  <= RESET_LONG_PULSE_TICKS;
      cfg.blink_half_period <= RESET_BLINK_HALF_PERIOD;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STABLE_TICKS:      cfg.stable_ticks      <= cfg_data[7:0];
        REG_POWER_ON_DELAY:    cfg.power_on_delay    <= cfg_data;
        REG_SHORT_PULSE_TICKS: cfg.short_pulse_ticks <= cfg_data;
        REG_LONG_PULSE_TICKS:  cfg.long_pulse_ticks  <= cfg_data;
        REG_BLINK_HALF_PERIOD: cfg.blink_half_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign full   = mid_full;
  assign accept = push && !mid_full;
  assign step   = !mid_empty && !out_full;

  dps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .raw_buttons  (raw_buttons),
    .stable_ticks (cfg.stable_ticks),
    .flags        (front_flags)
  );

  dps_fifo #(
    .WIDTH (DPS_BUTTONS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_flags),
    .rd_en   (step),
    .rd_data (mid_flags),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  dps_back u_back (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .flags  (mid_flags),
    .cfg    (cfg),
    .result (back_result)
  );

  dps_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (step),
    .wr_data (back_result),
    .rd_en   (pop && !empty),
    .rd_data (out_result),
    .full    (out_full),
    .empty   (empty)
  );

  assign power_mode      = out_result.power_mode;
  assign pulse_active    = out_result.pulse_active;
  assign status_lamp     = out_result.status_lamp;
  assign ready_lamp      = out_result.ready_lamp;
  assign pressed_buttons = out_result.pressed_buttons;
endmodule

>>> design/dps_fifo.sv
// ----------------------------------------------------------------------------
// dps_fifo
// Small register queue; one beat in and one beat out per cycle.
// ----------------------------------------------------------------------------
module dps_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

>>> design/dps_front.sv
// ----------------------------------------------------------------------------
// dps_front
// Debounce stage: tracks how long the raw level stays unchanged and updates
// the pressed flags once it has been stable long enough.
// ----------------------------------------------------------------------------
module dps_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [dps_pkg::DPS_BUTTONS_W-1:0] raw_buttons,
  input  logic [7:0]                       stable_ticks,
  output logic [dps_pkg::DPS_BUTTONS_W-1:0] flags
);
  import dps_pkg::*;

  logic [DPS_BUTTONS_W-1:0] last_raw;
  logic [DPS_BUTTONS_W-1:0] last_raw_next;
  logic [7:0]               equal_run;
  logic [7:0]               equal_run_next;
  logic [DPS_BUTTONS_W-1:0] pressed_flags;
  logic [DPS_BUTTONS_W-1:0] pressed_flags_next;

  always_comb begin
    last_raw_next      = last_raw;
    equal_run_next     = equal_run;
    pressed_flags_next = pressed_flags;
    if (raw_buttons == last_raw) begin
      if (equal_run < stable_ticks) begin
        equal_run_next = equal_run + 8'd1;
      end
    end else begin
      last_raw_next  = raw_buttons;
      equal_run_next = '0;
    end
    if (equal_run_next == stable_ticks) begin
      pressed_flags_next = ~raw_buttons;
    end
  end

  assign flags = pressed_flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw      <= '0;
      equal_run     <= '0;
      pressed_flags <= '0;
    end else if (accept) begin
      last_raw      <= last_raw_next;
      equal_run     <= equal_run_next;
      pressed_flags <= pressed_flags_next;
    end
  end
endmodule

>>> design/dps_back.sv
// ----------------------------------------------------------------------------
// dps_back
// Power state machine, pulse timer and lamp driver, advanced once per
// debounced beat.
// ----------------------------------------------------------------------------
module dps_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [dps_pkg::DPS_BUTTONS_W-1:0] flags,
  input  dps_pkg::cfg_t                    cfg,
  output dps_pkg::result_t                 result
);
  import dps_pkg::*;

  typedef enum logic [2:0] {
    MODE_OFF  = 3'b001,
    MODE_WAIT = 3'b010,
    MODE_ON   = 3'b100
  } mode_t;

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] power_cnt;
  logic [15:0] power_cnt_next;
  logic [15:0] power_cnt_dec;
  logic [1:0]  prev_hi;
  logic [1:0]  hi_now;
  logic [15:0] pulse_cnt;
  logic [15:0] pulse_cnt_next;
  logic [15:0] pulse_load;
  logic        pulse_level_next;
  logic [7:0]  blink_cnt;
  logic [7:0]  blink_cnt_next;
  logic [1:0]  lamps;
  logic [1:0]  lamps_next;

  assign power_cnt_dec = power_cnt - 16'd1;
  assign hi_now        = flags[3:2];

  always_comb begin
    mode_next      = mode;
    power_cnt_next = power_cnt;
    case (mode)
      MODE_OFF: begin
        if (flags[BTN_START]) begin
          mode_next      = MODE_WAIT;
          power_cnt_next = cfg.power_on_delay;
        end
      end
      MODE_WAIT: begin
        power_cnt_next = power_cnt_dec;
        if (power_cnt_dec == '0) begin
          mode_next = MODE_ON;
        end
        if (flags[BTN_OFF]) begin
          mode_next = MODE_OFF;
        end
      end
      MODE_ON: begin
        if (flags[BTN_OFF]) begin
          mode_next = MODE_OFF;
        end
      end
      default: begin
        mode_next = MODE_OFF;
      end
    endcase
  end

  always_comb begin
    pulse_load = pulse_cnt;
    if (hi_now[0] && !prev_hi[0]) begin
      pulse_load = cfg.short_pulse_ticks;
    end
    if (hi_now[1] && !prev_hi[1]) begin
      pulse_load = cfg.long_pulse_ticks;
    end
    pulse_cnt_next   = '0;
    pulse_level_next = 1'b0;
    if (mode_next == MODE_ON && pulse_load != '0) begin
      pulse_cnt_next   = pulse_load - 16'd1;
      pulse_level_next = 1'b1;
    end
  end

  always_comb begin
    blink_cnt_next = blink_cnt;
    lamps_next     = lamps;
    case (mode_next)
      MODE_OFF: begin
        blink_cnt_next = '0;
        lamps_next     = 2'b00;
      end
      MODE_WAIT: begin
        if (blink_cnt == '0) begin
          blink_cnt_next = cfg.blink_half_period;
          lamps_next[0]  = ~lamps[0];
        end else begin
          blink_cnt_next = blink_cnt - 8'd1;
        end
      end
      MODE_ON: begin
        lamps_next = 2'b11;
      end
      default: begin
        lamps_next = lamps;
      end
    endcase
  end

  always_comb begin
    case (mode_next)
      MODE_WAIT: result.power_mode = MODE_CODE_WAIT;
      MODE_ON:   result.power_mode = MODE_CODE_ON;
      default:   result.power_mode = MODE_CODE_OFF;
    endcase
    result.pulse_active    = pulse_level_next;
    result.status_lamp     = lamps_next[0];
    result.ready_lamp      = lamps_next[1];
    result.pressed_buttons = flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_OFF;
      power_cnt <= '0;
      prev_hi   <= '0;
      pulse_cnt <= '0;
      blink_cnt <= '0;
      lamps     <= '0;
    end else if (step) begin
      mode      <= mode_next;
      power_cnt <= power_cnt_next;
      prev_hi   <= hi_now;
      pulse_cnt <= pulse_cnt_next;
      blink_cnt <= blink_cnt_next;
      lamps     <= lamps_next;
    end
  end
endmodule

>>> design/dps_checker.sv
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks of the sequencer: lamp and pulse levels against the
// power mode, and a stalled result beat holding.
// ----------------------------------------------------------------------------
module dps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              empty,
  input logic                              pop,
  input logic [1:0]                        power_mode,
  input logic                              pulse_active,
  input logic                              status_lamp,
  input logic                              ready_lamp,
  input logic [dps_pkg::DPS_BUTTONS_W-1:0]  pressed_buttons
);
  import dps_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    !empty && power_mode == MODE_CODE_OFF |-> !status_lamp && !ready_lamp && !pulse_active)
  else $error("lamps or pulse active while power is off");

  assert property (@(posedge clk) disable iff (rst)
    !empty && (ready_lamp || pulse_active) |-> power_mode == MODE_CODE_ON)
  else $error("ready lamp or pulse outside on mode");

  assert property (@(posedge clk) disable iff (rst)
    !empty && power_mode == MODE_CODE_ON |-> status_lamp && ready_lamp)
  else $error("lamps not lit in on mode");

  assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(power_mode) && $stable(pressed_buttons))
  else $error("stalled result beat changed");
endmodule

bind debounced_power_sequencer_top dps_checker u_dps_checker (.*);

>>> test/tb_debounced_power_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_debounced_power_sequencer_top
// Feeds millisecond ticks of raw button levels into the sequencer and checks
// every result beat against a cycle-free model of debounce, power states,
// pulse timing and lamps. Directed ticks cover the corner cases, then random
// press and bounce sequences run under several register settings, with
// random stalls on both sides, a long result hold-off and a zero power delay.
// ----------------------------------------------------------------------------
module tb_debounced_power_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dps_pkg::*;

  localparam logic [3:0] RAW_RELEASED   = 4'hF;
  localparam logic [3:0] RAW_START      = 4'hD;
  localparam logic [3:0] RAW_OFF        = 4'hE;
  localparam logic [3:0] RAW_SHORT      = 4'hB;
  localparam logic [3:0] RAW_LONG       = 4'h7;
  localparam logic [3:0] RAW_BOTH_PULSE = 4'h3;
  localparam logic [3:0] RAW_BOTH_POWER = 4'hC;
  localparam logic [3:0] RAW_ALL        = 4'h0;

  logic                      clk;
  logic                      rst;
  logic                      push;
  logic                      full;
  logic [DPS_BUTTONS_W-1:0]  raw_buttons;
  logic                      empty;
  logic                      pop;
  logic [1:0]                power_mode;
  logic                      pulse_active;
  logic                      status_lamp;
  logic                      ready_lamp;
  logic [DPS_BUTTONS_W-1:0]  pressed_buttons;
  logic                      cfg_write;
  logic [DPS_CFG_IDX_W-1:0]  cfg_index;
  logic [DPS_CFG_DATA_W-1:0] cfg_data;

  debounced_power_sequencer_top u_top (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .raw_buttons     (raw_buttons),
    .empty           (empty),
    .pop             (pop),
    .power_mode      (power_mode),
    .pulse_active    (pulse_active),
    .status_lamp     (status_lamp),
    .ready_lamp      (ready_lamp),
    .pressed_buttons (pressed_buttons),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  cfg_t        cfg_shadow;
  logic [3:0]  seq_last_raw;
  logic [7:0]  seq_run;
  logic [3:0]  seq_pressed;
  logic [1:0]  seq_mode;
  logic [15:0] seq_power_cnt;
  logic [1:0]  seq_prev_pulse_btn;
  logic [15:0] seq_pulse_cnt;
  logic        seq_pulse;
  logic [7:0]  seq_blink_cnt;
  logic [1:0]  seq_lamps;

  result_t     expected_results[$];
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned sink_hold_req;
  bit          tx_idle_on;
  bit          rx_idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_debounced_power_sequencer_top failed");
    $finish;
  end

  function automatic result_t sequence_tick(input logic [3:0] raw);
    result_t    r;
    logic [1:0] pulse_btn;
    if (raw == seq_last_raw) begin
      if (seq_run < cfg_shadow.stable_ticks) seq_run = seq_run + 8'd1;
    end else begin
      seq_last_raw = raw;
      seq_run = 8'd0;
    end
    if (seq_run == cfg_shadow.stable_ticks) seq_pressed = ~raw;

    case (seq_mode)
      MODE_CODE_OFF: begin
        if (seq_pressed[BTN_START]) begin
          seq_mode = MODE_CODE_WAIT;
          seq_power_cnt = cfg_shadow.power_on_delay;
        end
      end
      MODE_CODE_WAIT: begin
        seq_power_cnt = seq_power_cnt - 16'd1;
        if (seq_power_cnt == 16'd0) seq_mode = MODE_CODE_ON;
        if (seq_pressed[BTN_OFF]) seq_mode = MODE_CODE_OFF;
      end
      MODE_CODE_ON: begin
        if (seq_pressed[BTN_OFF]) seq_mode = MODE_CODE_OFF;
      end
      default: ;
    endcase

    pulse_btn = seq_pressed[3:2];
    if (seq_mode == MODE_CODE_ON) begin
      if (pulse_btn[0] && !seq_prev_pulse_btn[0]) seq_pulse_cnt = cfg_shadow.short_pulse_ticks;
      if (pulse_btn[1] && !seq_prev_pulse_btn[1]) seq_pulse_cnt = cfg_shadow.long_pulse_ticks;
      if (seq_pulse_cnt != 16'd0) begin
        seq_pulse_cnt = seq_pulse_cnt - 16'd1;
        seq_pulse = 1'b1;
      end else begin
        seq_pulse = 1'b0;
      end
    end else begin
      seq_pulse_cnt = 16'd0;
      seq_pulse = 1'b0;
    end
    seq_prev_pulse_btn = pulse_btn;

    case (seq_mode)
      MODE_CODE_OFF: begin
        seq_lamps = 2'b00;
        seq_blink_cnt = 8'd0;
      end
      MODE_CODE_WAIT: begin
        if (seq_blink_cnt == 8'd0) begin
          seq_blink_cnt = cfg_shadow.blink_half_period;
          seq_lamps[0] = ~seq_lamps[0];
        end else begin
          seq_blink_cnt = seq_blink_cnt - 8'd1;
        end
      end
      MODE_CODE_ON: seq_lamps = 2'b11;
      default: ;
    endcase

    r.power_mode      = seq_mode;
    r.pulse_active    = seq_pulse;
    r.status_lamp     = seq_lamps[0];
    r.ready_lamp      = seq_lamps[1];
    r.pressed_buttons = seq_pressed;
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  task automatic send_tick(input logic [3:0] raw);
    int unsigned gap;
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      push <= 1'b0;
      raw_buttons <= 4'($urandom);
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    raw_buttons <= raw;
    do @(posedge clk); while (full);
    expected_results.push_back(sequence_tick(raw));
    ticks_sent++;
  endtask

  task automatic hold_level(input logic [3:0] raw, input int unsigned n);
    repeat (n) send_tick(raw);
  endtask

  task automatic drain_block();
    @(negedge clk);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [DPS_CFG_IDX_W-1:0] idx,
                                input logic [DPS_CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_STABLE_TICKS:      cfg_shadow.stable_ticks      = value[7:0];
      REG_POWER_ON_DELAY:    cfg_shadow.power_on_delay    = value;
      REG_SHORT_PULSE_TICKS: cfg_shadow.short_pulse_ticks = value;
      REG_LONG_PULSE_TICKS:  cfg_shadow.long_pulse_ticks  = value;
      REG_BLINK_HALF_PERIOD: cfg_shadow.blink_half_period = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] stable, input logic [15:0] delay,
                                input logic [15:0] short_len, input logic [15:0] long_len,
                                input logic [7:0] blink);
    drain_block();
    write_register(REG_STABLE_TICKS, {8'($urandom), stable});
    write_register(REG_POWER_ON_DELAY, delay);
    write_register(REG_SHORT_PULSE_TICKS, short_len);
    write_register(REG_LONG_PULSE_TICKS, long_len);
    write_register(REG_BLINK_HALF_PERIOD, {8'($urandom), blink});
  endtask

  function automatic logic [3:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return RAW_RELEASED;
    if (roll < 40) return RAW_START;
    if (roll < 48) return RAW_OFF;
    if (roll < 60) return RAW_SHORT;
    if (roll < 72) return RAW_LONG;
    if (roll < 78) return RAW_BOTH_PULSE;
    if (roll < 80) return RAW_BOTH_POWER;
    return 4'($urandom);
  endfunction

  task automatic run_button_phase(input int unsigned n);
    int unsigned target;
    int unsigned stable;
    int unsigned len;
    target = ticks_sent + n;
    stable = 32'(cfg_shadow.stable_ticks);
    while (ticks_sent < target) begin
      if ($urandom_range(0, 3) != 0) len = stable + 1 + $urandom_range(0, 6);
      else len = $urandom_range(1, stable + 1);
      hold_level(pick_level(), len);
    end
  endtask

  task automatic test_reset_values();
    hold_level(RAW_START, 6);
    hold_level(RAW_OFF, 6);
  endtask

  task automatic test_directed();
    apply_settings(8'd0, 16'd1, 16'd0, 16'd3, 8'd0);
    send_tick(RAW_ALL);
    send_tick(RAW_RELEASED);
    send_tick(RAW_SHORT);
    send_tick(RAW_BOTH_PULSE);
    send_tick(RAW_RELEASED);
    hold_level(RAW_BOTH_PULSE, 3);
    send_tick(RAW_OFF);
    send_tick(RAW_RELEASED);
    send_tick(RAW_START);
    send_tick(RAW_RELEASED);
    send_tick(RAW_LONG);
    send_tick(RAW_OFF);
  endtask

  task automatic test_random_phases();
    apply_settings(8'($urandom_range(1, 3)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)),
                   8'($urandom_range(0, 3)));
    run_button_phase(250);
    apply_settings(8'd4, 16'hFFFF, 16'd0, 16'($urandom_range(1, 30)), 8'd255);
    run_button_phase(150);
    apply_settings(8'd255, 16'd1, 16'hFFFF, 16'hFFFF, 8'($urandom_range(0, 255)));
    run_button_phase(100);
    apply_settings(8'd0, 16'($urandom_range(1, 12)), 16'($urandom_range(0, 9)),
                   16'($urandom_range(0, 9)), 8'($urandom_range(0, 2)));
    run_button_phase(150);
  endtask

  task automatic test_backpressure();
    apply_settings(8'd1, 16'd2, 16'd3, 16'd5, 8'd1);
    tx_idle_on = 1'b0;
    sink_hold_req = 80;
    repeat (40) send_tick(pick_level());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_zero_power_delay();
    apply_settings(8'd1, 16'd0, 16'd5, 16'd9, 8'd255);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_level(RAW_START, 3);
    hold_level(RAW_RELEASED, 12);
    hold_level(RAW_LONG, 4);
    hold_level(RAW_OFF, 3);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_final_stretch();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    apply_settings(8'd2, 16'd3, 16'd4, 16'd6, 8'd1);
    run_button_phase(200);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req != 0) begin
        stall_left = sink_hold_req;
        sink_hold_req = 0;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("beat with nothing expected", 0, 32'(power_mode));
        end else begin
          want = expected_results.pop_front();
          if (power_mode !== want.power_mode)
            flag_mismatch("power_mode", 32'(want.power_mode), 32'(power_mode));
          if (pulse_active !== want.pulse_active)
            flag_mismatch("pulse_active", 32'(want.pulse_active), 32'(pulse_active));
          if (status_lamp !== want.status_lamp)
            flag_mismatch("status_lamp", 32'(want.status_lamp), 32'(status_lamp));
          if (ready_lamp !== want.ready_lamp)
            flag_mismatch("ready_lamp", 32'(want.ready_lamp), 32'(ready_lamp));
          if (pressed_buttons !== want.pressed_buttons)
            flag_mismatch("pressed_buttons", 32'(want.pressed_buttons),
                          32'(pressed_buttons));
        end
      end
    end
  end

  initial begin : test_sequence
    rst         = 1'b1;
    push        = 1'b0;
    raw_buttons = RAW_RELEASED;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    mismatches    = 0;
    ticks_sent    = 0;
    sink_hold_req = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;

    cfg_shadow.stable_ticks      = RESET_STABLE_TICKS;
    cfg_shadow.power_on_delay    = RESET_POWER_ON_DELAY;
    cfg_shadow.short_pulse_ticks = RESET_SHORT_PULSE_TICKS;
    cfg_shadow.long_pulse_ticks  = RESET_LONG_PULSE_TICKS;
    cfg_shadow.blink_half_period = RESET_BLINK_HALF_PERIOD;
    seq_last_raw       = '0;
    seq_run            = '0;
    seq_pressed        = '0;
    seq_mode           = MODE_CODE_OFF;
    seq_power_cnt      = '0;
    seq_prev_pulse_btn = '0;
    seq_pulse_cnt      = '0;
    seq_pulse          = 1'b0;
    seq_blink_cnt      = '0;
    seq_lamps          = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_zero_power_delay();
    test_final_stretch();

    drain_block();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_debounced_power_sequencer_top passed");
    end else begin
      $display("tb_debounced_power_sequencer_top failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/dps_pkg.sv
design/dps_fifo.sv
design/dps_front.sv
design/dps_back.sv
design/debounced_power_sequencer_top.sv
design/dps_checker.sv
test/tb_debounced_power_sequencer_top.sv
